[hdl/oas_pkg.sv]
// oas_pkg: shared types, constants and the arctangent table of the steering block
// item and result payload structs, configuration register codes
// no dependencies
package oas_pkg;

  localparam int unsigned SENSE_W       = 12;
  localparam int unsigned COORD_W       = 16;
  localparam int unsigned WHEEL_W       = 16;
  localparam int unsigned FACTOR_W      = 9;
  localparam int unsigned CFG_INDEX_W   = 3;
  localparam int unsigned CFG_DATA_W    = 16;
  localparam int unsigned ATAN_ITER_DEF = 14;
  localparam int unsigned ATAN_ITER_MAX = 20;
  localparam int unsigned ANGLE_W       = 24;  // q20 radians
  localparam int unsigned QUO_BITS      = 8;

  localparam logic signed [ANGLE_W-1:0] HALF_PI_Q20 = 24'sd1647099;
  localparam logic signed [17:0]        PI_Q12      = 18'sd12868;
  localparam logic signed [17:0]        TWO_PI_Q12  = 18'sd25736;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_GAP_THRESHOLD    = 3'd0,
    REG_SATURATION_LEVEL = 3'd1,
    REG_TOP_SPEED        = 3'd2,
    REG_HEADING_BAND     = 3'd3,
    REG_ARRIVE_RADIUS    = 3'd4,
    REG_TARGET_X         = 3'd5,
    REG_TARGET_Z         = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [SENSE_W-1:0]        sense_left_a;
    logic [SENSE_W-1:0]        sense_left_b;
    logic [SENSE_W-1:0]        sense_left_c;
    logic [SENSE_W-1:0]        sense_right_a;
    logic [SENSE_W-1:0]        sense_right_b;
    logic [SENSE_W-1:0]        sense_right_c;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [COORD_W-1:0] north_x;
    logic signed [COORD_W-1:0] north_z;
  } oas_in_t;

  typedef struct packed {
    logic [WHEEL_W-1:0]  left_wheel;
    logic [WHEEL_W-1:0]  right_wheel;
    logic                target_reached;
    logic                obstacle_left;
    logic                obstacle_right;
    logic [FACTOR_W-1:0] turn_factor;
  } oas_out_t;

  // atan(2^-i) in q20
  function automatic logic signed [ANGLE_W-1:0] atan_q20(input int unsigned i);
    logic signed [ANGLE_W-1:0] a;
    unique case (i)
      0:  a = 24'sd823550;
      1:  a = 24'sd486170;
      2:  a = 24'sd256879;
      3:  a = 24'sd130396;
      4:  a = 24'sd65451;
      5:  a = 24'sd32757;
      6:  a = 24'sd16383;
      7:  a = 24'sd8192;
      8:  a = 24'sd4096;
      9:  a = 24'sd2048;
      10: a = 24'sd1024;
      11: a = 24'sd512;
      12: a = 24'sd256;
      13: a = 24'sd128;
      14: a = 24'sd64;
      15: a = 24'sd32;
      16: a = 24'sd16;
      17: a = 24'sd8;
      18: a = 24'sd4;
      19: a = 24'sd2;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

[hdl/obstacle_avoid_steering.sv]
// obstacle_avoid_steering: pipelined obstacle avoidance and heading steering
// uses oas_pkg (payload structs, register codes, arctangent table)
//
// Usage
//   item channel: item_valid / item_stall / item carries six proximity readings,
//   the robot position and a compass vector. result channel: result_valid /
//   result_stall / result gives both wheel speeds, the arrival flag, both
//   obstacle flags and the turn factor. one result per item, in order.
//   configuration: cfg_write with cfg_index and cfg_data writes one register
//   in a cycle; write only while no item is in flight.
// Pipeline
//   stages in order: input register, sensor stage, one cordic rotation per
//   stage for both angles, angle wrap stage, output register. the quotient
//   of the turn factor is formed one bit per stage alongside the first eight
//   rotations. throughput is one item per cycle unless a result is held
//   under result_stall.
// Reset
//   rst empties the pipeline and loads the register defaults.
// Stall
//   while a result waits under result_stall the whole pipeline holds and
//   item_stall is raised; nothing is lost or repeated.
module obstacle_avoid_steering
  import oas_pkg::*;
#(
  parameter int unsigned ATAN_ITERATIONS = ATAN_ITER_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  oas_in_t                item,
  output logic                   result_valid,
  input  logic                   result_stall,
  output oas_out_t               result,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned N  = ATAN_ITERATIONS;
  localparam int unsigned CW = 32;

  typedef enum logic [1:0] {FAC_FULL, FAC_DIV, FAC_SAT} fac_mode_t;

  typedef struct packed {
    logic signed [CW-1:0]      x;
    logic signed [CW-1:0]      y;
    logic signed [ANGLE_W-1:0] z;
    logic                      zero;
  } cvec_t;

  typedef struct packed {
    cvec_t              dir;
    cvec_t              front;
    logic signed [16:0] dx;
    logic signed [16:0] dz;
    logic [33:0]        sqx;
    logic [33:0]        sqz;
    logic               near;
    logic [18:0]        rem;
    logic [11:0]        dv;
    logic [7:0]         quo;
    fac_mode_t          fmode;
    logic               obl;
    logic               obr;
  } work_t;

  typedef struct packed {
    logic signed [17:0]  r;
    logic [FACTOR_W-1:0] fac;
    logic                near;
    logic                obl;
    logic                obr;
  } wrap_t;

  // configuration registers
  logic [11:0]               gap_threshold;
  logic [11:0]               saturation_level;
  logic [7:0]                top_speed;
  logic [13:0]               heading_band;
  logic [15:0]               arrive_radius;
  logic signed [COORD_W-1:0] target_x;
  logic signed [COORD_W-1:0] target_z;
  logic [31:0]               tol_sq;
  logic [15:0]               turn_speed;

  logic    advance;
  logic    in_v;
  oas_in_t in_q;
  logic    stg_v [0:N];
  work_t   stg   [0:N];
  work_t   nxt   [0:N-1];
  work_t   pre;
  logic    wrap_v;
  wrap_t   wrap_q;
  wrap_t   wrap_next;
  oas_out_t result_next;

  assign advance    = !(result_valid && result_stall);
  assign item_stall = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_threshold    <= 12'd600;
      saturation_level <= 12'd1024;
      top_speed        <= 8'd12;
      heading_band     <= 14'd410;
      arrive_radius    <= 16'd26;
      target_x         <= 16'sd0;
      target_z         <= 16'sd896;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GAP_THRESHOLD:    gap_threshold    <= cfg_data[11:0];
        REG_SATURATION_LEVEL: saturation_level <= cfg_data[11:0];
        REG_TOP_SPEED:        top_speed        <= cfg_data[7:0];
        REG_HEADING_BAND:     heading_band     <= cfg_data[13:0];
        REG_ARRIVE_RADIUS:    arrive_radius    <= cfg_data;
        REG_TARGET_X:         target_x         <= $signed(cfg_data);
        REG_TARGET_Z:         target_z         <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // derived from registers, settle before any item arrives
  logic [34:0] turn_prod;
  assign turn_prod = 35'({top_speed, 9'b0}) * 35'd43691;

  always_ff @(posedge clk) begin
    tol_sq     <= 32'(arrive_radius) * 32'(arrive_radius);
    turn_speed <= 16'(turn_prod >> 17);  // top_speed*512/3
  end

  function automatic cvec_t pre_rotate(input logic signed [16:0] vx,
                                       input logic signed [16:0] vy);
    cvec_t                v;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    sx     = $signed({{3{vx[16]}}, vx, 12'b0});
    sy     = $signed({{3{vy[16]}}, vy, 12'b0});
    v.zero = (vx == '0) && (vy == '0);
    v.x    = sx;
    v.y    = sy;
    v.z    = '0;
    if (sx < 0) begin
      if (sy >= 0) begin
        v.x = sy;
        v.y = -sx;
        v.z = HALF_PI_Q20;
      end else begin
        v.x = -sy;
        v.y = sx;
        v.z = -HALF_PI_Q20;
      end
    end
    return v;
  endfunction

  function automatic cvec_t rotate(input cvec_t v, input int unsigned i);
    cvec_t r;
    r = v;
    if (v.y >= 0) begin
      r.x = v.x + (v.y >>> i);
      r.y = v.y - (v.x >>> i);
      r.z = v.z + atan_q20(i);
    end else begin
      r.x = v.x - (v.y >>> i);
      r.y = v.y + (v.x >>> i);
      r.z = v.z - atan_q20(i);
    end
    return r;
  endfunction

  function automatic logic signed [17:0] angle_q12(input cvec_t v);
    logic signed [ANGLE_W-1:0] t;
    t = v.z + 24'sd128;
    return v.zero ? 18'sd0 : 18'(t >>> 8);
  endfunction

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (advance) begin
      in_v <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      in_q <= item;
    end
  end

  // sensor stage: side decision, largest reading, cordic pre-rotation
  always_comb begin
    logic [13:0] suml;
    logic [13:0] sumr;
    logic        anyl;
    logic        anyr;
    logic [11:0] maxl;
    logic [11:0] maxr;
    logic [11:0] m;
    logic        lwin;
    suml = 14'(in_q.sense_left_a) + 14'(in_q.sense_left_b) + 14'(in_q.sense_left_c);
    sumr = 14'(in_q.sense_right_a) + 14'(in_q.sense_right_b) + 14'(in_q.sense_right_c);
    anyl = (in_q.sense_left_a > gap_threshold) || (in_q.sense_left_b > gap_threshold) ||
           (in_q.sense_left_c > gap_threshold);
    anyr = (in_q.sense_right_a > gap_threshold) || (in_q.sense_right_b > gap_threshold) ||
           (in_q.sense_right_c > gap_threshold);
    maxl = in_q.sense_left_a;
    if (in_q.sense_left_b > maxl) maxl = in_q.sense_left_b;
    if (in_q.sense_left_c > maxl) maxl = in_q.sense_left_c;
    maxr = in_q.sense_right_a;
    if (in_q.sense_right_b > maxr) maxr = in_q.sense_right_b;
    if (in_q.sense_right_c > maxr) maxr = in_q.sense_right_c;
    lwin = suml > sumr;
    pre.obl = anyl && lwin;
    pre.obr = anyr && !lwin;
    m = pre.obl ? maxl : (pre.obr ? maxr : 12'd0);
    if (m > saturation_level) pre.fmode = FAC_SAT;
    else if (m > gap_threshold) pre.fmode = FAC_DIV;
    else pre.fmode = FAC_FULL;
    pre.rem   = {12'(m - gap_threshold), 7'b0};
    pre.dv    = saturation_level - gap_threshold;
    pre.quo   = '0;
    pre.dx    = 17'(target_x) - 17'(in_q.pos_x);
    pre.dz    = 17'(target_z) - 17'(in_q.pos_z);
    pre.sqx   = '0;
    pre.sqz   = '0;
    pre.near  = 1'b0;
    pre.dir   = pre_rotate(pre.dx, pre.dz);
    pre.front = pre_rotate(-17'(in_q.north_x), 17'(in_q.north_z));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_v[0] <= 1'b0;
    end else if (advance) begin
      stg_v[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stg[0] <= pre;
    end
  end

  // one rotation per stage; quotient bits, squares and the radius test ride along
  for (genvar j = 0; j < N; j++) begin : g_rot
    always_comb begin
      logic [19:0]        sh;
      logic signed [33:0] p;
      logic signed [33:0] q;
      logic [34:0]        d2;
      nxt[j]       = stg[j];
      nxt[j].dir   = rotate(stg[j].dir, j);
      nxt[j].front = rotate(stg[j].front, j);
      sh = (20'(stg[j].dv) << (QUO_BITS - 1)) >> j;
      if (j < QUO_BITS && {1'b0, stg[j].rem} >= sh) begin
        nxt[j].rem = stg[j].rem - sh[18:0];
        nxt[j].quo = stg[j].quo | (8'h80 >> j);
      end
      p  = stg[j].dx * stg[j].dx;
      q  = stg[j].dz * stg[j].dz;
      d2 = 35'(stg[j].sqx) + 35'(stg[j].sqz);
      if (j == 0) begin
        nxt[j].sqx = $unsigned(p);
        nxt[j].sqz = $unsigned(q);
      end
      if (j == 1) begin
        nxt[j].near = d2 < 35'(tol_sq);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stg_v[j+1] <= 1'b0;
      end else if (advance) begin
        stg_v[j+1] <= stg_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        stg[j+1] <= nxt[j];
      end
    end
  end

  // heading difference wrapped to [0, 2pi), turn factor
  always_comb begin
    logic signed [17:0] r;
    r = angle_q12(stg[N].dir) - angle_q12(stg[N].front);
    if (r < 0) r = r + TWO_PI_Q12;
    if (r < 0) r = r + TWO_PI_Q12;
    if (r >= TWO_PI_Q12) r = r - TWO_PI_Q12;
    if (r >= TWO_PI_Q12) r = r - TWO_PI_Q12;
    wrap_next.r    = r;
    wrap_next.near = stg[N].near;
    wrap_next.obl  = stg[N].obl;
    wrap_next.obr  = stg[N].obr;
    unique case (stg[N].fmode)
      FAC_SAT:  wrap_next.fac = 9'd128;
      FAC_DIV:  wrap_next.fac = 9'd256 - 9'(stg[N].quo);
      FAC_FULL: wrap_next.fac = 9'd256;
      default:  wrap_next.fac = 9'd256;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_v <= 1'b0;
    end else if (advance) begin
      wrap_v <= stg_v[N];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      wrap_q <= wrap_next;
    end
  end

  // wheel speeds
  always_comb begin
    logic signed [17:0] beta;
    logic signed [17:0] tol;
    logic [15:0]        full;
    logic [15:0]        slow;
    beta = wrap_q.r - PI_Q12;
    tol  = $signed({4'b0, heading_band});
    full = {top_speed, 8'b0};
    slow = 16'(17'(top_speed) * 17'(wrap_q.fac));
    result_next.left_wheel     = full;
    result_next.right_wheel    = full;
    result_next.target_reached = 1'b0;
    result_next.obstacle_left  = wrap_q.obl;
    result_next.obstacle_right = wrap_q.obr;
    result_next.turn_factor    = wrap_q.fac;
    priority if (wrap_q.near) begin
      result_next.left_wheel     = '0;
      result_next.right_wheel    = '0;
      result_next.target_reached = 1'b1;
    end else if (wrap_q.obl) begin
      result_next.right_wheel = slow;
    end else if (wrap_q.obr) begin
      result_next.left_wheel = slow;
    end else if (beta > tol) begin
      result_next.right_wheel = turn_speed;
    end else if (beta < -tol) begin
      result_next.left_wheel = turn_speed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= wrap_v;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.obstacle_left && result.obstacle_right))
    else $error("both obstacle flags set");

  a_reached_stops: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.target_reached |->
      result.left_wheel == '0 && result.right_wheel == '0)
    else $error("wheels turn at the target");

  a_factor_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.turn_factor >= 9'd128 && result.turn_factor <= 9'd256)
    else $error("turn factor out of range");

  a_clear_full_factor: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.obstacle_left && !result.obstacle_right |->
      result.turn_factor == 9'd256)
    else $error("factor reduced without obstacle");

  a_left_keeps_left: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.obstacle_left && !result.target_reached |->
      result.left_wheel == {top_speed, 8'b0})
    else $error("left wheel slowed for left obstacle");

endmodule

[sim/obstacle_avoid_steering_tb.sv]
// obstacle_avoid_steering_tb: self-checking bench for the steering block
// drives items, registers and result stall; predicts every result in a scoreboard
// depends on oas_pkg and hdl/obstacle_avoid_steering.sv
`timescale 1ns / 100ps

module obstacle_avoid_steering_tb;
  import oas_pkg::*;

  localparam int unsigned ITER      = 14;
  localparam int unsigned LATENCY   = ITER + 4;
  localparam int unsigned DOG_LIMIT = 3000;

  // turn, heading and arrival prediction with its own register copy
  class steer_scoreboard;
    logic [11:0]        gap_thr, sat_lvl;
    logic [7:0]         speed;
    logic [13:0]        ang_tol;
    logic [15:0]        dist_tol;
    logic signed [15:0] tgt_x, tgt_z;
    oas_out_t           pending[$];
    int                 mismatches;
    longint             atan_tab[20] = '{823550, 486170, 256879, 130396, 65451, 32757,
                                         16383, 8192, 4096, 2048, 1024, 512, 256, 128,
                                         64, 32, 16, 8, 4, 2};

    function new();
      gap_thr = 600; sat_lvl = 1024; speed = 12; ang_tol = 410; dist_tol = 26;
      tgt_x = 0; tgt_z = 896; mismatches = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [15:0] val);
      case (idx)
        REG_GAP_THRESHOLD:    gap_thr = val[11:0];
        REG_SATURATION_LEVEL: sat_lvl = val[11:0];
        REG_TOP_SPEED:        speed = val[7:0];
        REG_HEADING_BAND:     ang_tol = val[13:0];
        REG_ARRIVE_RADIUS:    dist_tol = val;
        REG_TARGET_X:         tgt_x = val;
        REG_TARGET_Z:         tgt_z = val;
        default: ;
      endcase
    endfunction

    // heading angle in q12 radians, rotations in q20
    function longint heading(longint y, longint x);
      longint z, t, xs, ys;
      z = 0;
      if (x == 0 && y == 0) return 0;
      x = x * 4096;
      y = y * 4096;
      if (x < 0) begin
        if (y >= 0) begin
          t = x; x = y; y = -t; z = 1647099;
        end else begin
          t = x; x = -y; y = t; z = -1647099;
        end
      end
      for (int i = 0; i < ITER; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x += ys; y -= xs; z += atan_tab[i];
        end else begin
          x -= ys; y += xs; z -= atan_tab[i];
        end
      end
      return (z + 128) >>> 8;
    endfunction

    function void note_item(oas_in_t it);
      longint sl[3], sr[3], suml, sumr, m, fac, full, lw, rw, dx, dz, r, beta, g, sat;
      bit anyl, anyr, obl, obr, reached;
      oas_out_t e;
      sl = '{it.sense_left_a, it.sense_left_b, it.sense_left_c};
      sr = '{it.sense_right_a, it.sense_right_b, it.sense_right_c};
      g = gap_thr; sat = sat_lvl;
      suml = sl[0] + sl[1] + sl[2];
      sumr = sr[0] + sr[1] + sr[2];
      anyl = sl[0] > g || sl[1] > g || sl[2] > g;
      anyr = sr[0] > g || sr[1] > g || sr[2] > g;
      obl = anyl && suml > sumr;
      obr = anyr && suml <= sumr;
      m = 0;
      if (obl) m = (sl[0] > sl[1] ? sl[0] : sl[1]) > sl[2] ?
                   (sl[0] > sl[1] ? sl[0] : sl[1]) : sl[2];
      else if (obr) m = (sr[0] > sr[1] ? sr[0] : sr[1]) > sr[2] ?
                        (sr[0] > sr[1] ? sr[0] : sr[1]) : sr[2];
      fac = 256;
      if (m > sat) fac = 128;
      else if (m > g) fac = 256 - ((m - g) * 128) / (sat - g);
      full = longint'(speed) * 256;
      lw = full; rw = full; reached = 0;
      dx = longint'(tgt_x) - longint'($signed(it.pos_x));
      dz = longint'(tgt_z) - longint'($signed(it.pos_z));
      if (dx * dx + dz * dz < longint'(dist_tol) * longint'(dist_tol)) begin
        lw = 0; rw = 0; reached = 1;
      end else if (obl) begin
        rw = longint'(speed) * fac;
      end else if (obr) begin
        lw = longint'(speed) * fac;
      end else begin
        r = heading(dz, dx) - heading(longint'($signed(it.north_z)),
                                      -longint'($signed(it.north_x)));
        while (r < 0) r += 25736;
        while (r >= 25736) r -= 25736;
        beta = r - 12868;
        if (beta > longint'(ang_tol)) rw = (longint'(speed) * 512) / 3;
        else if (beta < -longint'(ang_tol)) lw = (longint'(speed) * 512) / 3;
      end
      e.left_wheel = lw[15:0];
      e.right_wheel = rw[15:0];
      e.target_reached = reached;
      e.obstacle_left = obl;
      e.obstacle_right = obr;
      e.turn_factor = fac[8:0];
      pending.push_back(e);
    endfunction

    function void check_result(oas_out_t got);
      oas_out_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      e = pending.pop_front();
      if (got.left_wheel !== e.left_wheel || got.right_wheel !== e.right_wheel ||
          got.target_reached !== e.target_reached || got.obstacle_left !== e.obstacle_left ||
          got.obstacle_right !== e.obstacle_right || got.turn_factor !== e.turn_factor) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp lw=%0d rw=%0d rch=%b ol=%b or=%b tf=%0d ",
                    "got lw=%0d rw=%0d rch=%b ol=%b or=%b tf=%0d"},
                   e.left_wheel, e.right_wheel, e.target_reached, e.obstacle_left,
                   e.obstacle_right, e.turn_factor, got.left_wheel, got.right_wheel,
                   got.target_reached, got.obstacle_left, got.obstacle_right, got.turn_factor);
      end
    endfunction
  endclass

  logic                   clk, rst;
  logic                   item_valid, item_stall, result_valid, result_stall;
  oas_in_t                item;
  oas_out_t               result;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  steer_scoreboard sb = new();
  bit  calm;         // no idling on either side
  bit  hold_req;     // ask the receiver for a long hold-off
  bit  hold_used;
  int  hold_cnt;
  int  dog;

  obstacle_avoid_steering uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // result side: checking and random stall
  initial begin
    result_stall = 1'b0;
    hold_cnt = 0;
    hold_used = 0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) sb.check_result(result);
      if (hold_req && !hold_used) begin
        hold_cnt = 120;
        hold_used = 1;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= !calm && ($urandom_range(99) < 18);
      end
    end
  end

  // watchdog on cycles with no transfer
  initial begin
    dog = 0;
    forever begin
      @(posedge clk);
      if ((item_valid && !item_stall) || (result_valid && !result_stall)) dog = 0;
      else dog++;
      if (dog >= DOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_item(oas_in_t it);
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    sb.note_item(it);
    if (!calm && $urandom_range(99) < 22) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic set_reg(cfg_reg_t idx, logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [11:0] pick_sense();
    case ($urandom_range(5))
      0: return 12'(sb.gap_thr + $urandom_range(3) - 1);
      1: return 12'(sb.sat_lvl + $urandom_range(3) - 1);
      2: return 12'($urandom_range(4095));
      3: return 12'($urandom_range(sb.gap_thr));
      default: return 12'($urandom_range(1300));
    endcase
  endfunction

  function automatic oas_in_t rand_item();
    oas_in_t it;
    it.sense_left_a = pick_sense();
    it.sense_left_b = pick_sense();
    it.sense_left_c = pick_sense();
    it.sense_right_a = pick_sense();
    it.sense_right_b = pick_sense();
    it.sense_right_c = pick_sense();
    if ($urandom_range(2) == 0) begin
      // all quiet so the heading path decides
      it.sense_left_a = 12'($urandom_range(sb.gap_thr));
      it.sense_right_a = 12'($urandom_range(sb.gap_thr));
      it.sense_left_b = 12'($urandom_range(sb.gap_thr));
      it.sense_right_b = 12'($urandom_range(sb.gap_thr));
      it.sense_left_c = 12'($urandom_range(sb.gap_thr));
      it.sense_right_c = 12'($urandom_range(sb.gap_thr));
    end
    if ($urandom_range(6) == 0) begin
      it.pos_x = sb.tgt_x + $signed(16'($urandom_range(64))) - 16'sd32;
      it.pos_z = sb.tgt_z + $signed(16'($urandom_range(64))) - 16'sd32;
    end else begin
      it.pos_x = 16'($urandom);
      it.pos_z = 16'($urandom);
    end
    if ($urandom_range(4) == 0) begin
      it.north_x = 16'($urandom);
      it.north_z = 16'($urandom);
    end else begin
      it.north_x = $signed(16'($urandom_range(32768))) - 16'sd16384;
      it.north_z = $signed(16'($urandom_range(32768))) - 16'sd16384;
    end
    return it;
  endfunction

  function automatic oas_in_t mk(int la, int lb, int lc, int ra, int rb, int rc,
                                 int px, int pz, int nx, int nz);
    oas_in_t it;
    it = {12'(la), 12'(lb), 12'(lc), 12'(ra), 12'(rb), 12'(rc),
          16'(px), 16'(pz), 16'(nx), 16'(nz)};
    return it;
  endfunction

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 0;
    hold_req = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed items at reset settings
    send_item(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 16384));
    send_item(mk(4095, 4095, 4095, 4095, 4095, 4095, -32768, -32768, -32768, -32768));
    send_item(mk(900, 100, 100, 100, 100, 100, 0, 0, 0, 16384));      // left obstacle
    send_item(mk(100, 100, 100, 100, 800, 100, 0, 0, 0, 16384));      // right obstacle
    send_item(mk(700, 700, 0, 0, 0, 1400, 0, 0, 0, 16384));           // tie goes right
    send_item(mk(601, 0, 0, 0, 0, 0, 0, 0, 0, 16384));                // just over gap
    send_item(mk(600, 0, 0, 0, 0, 0, 0, 0, 0, 16384));                // at gap
    send_item(mk(1024, 0, 0, 0, 0, 0, 0, 0, 0, 16384));               // at saturation
    send_item(mk(1025, 0, 0, 0, 0, 0, 0, 0, 0, 16384));               // past saturation
    send_item(mk(0, 0, 0, 0, 0, 0, 0, 896, 0, 16384));                // on the target
    send_item(mk(0, 0, 0, 0, 0, 0, 26, 896, 0, 16384));               // on the radius
    send_item(mk(2000, 0, 0, 0, 0, 0, 0, 890, 0, 16384));             // reached with obstacle
    send_item(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));                      // zero front vector
    send_item(mk(0, 0, 0, 0, 0, 0, 5000, 0, 16384, 0));               // heading turn
    send_item(mk(0, 0, 0, 0, 0, 0, -5000, 0, 16384, 0));
    send_item(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, -16384));                 // facing away
    send_item(mk(0, 0, 0, 0, 0, 0, 32767, 32767, -16384, 16384));
    send_item(mk(0, 0, 0, 0, 0, 0, 0, 0, 300, 16384));                // inside dead band
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        1: begin
          set_reg(REG_GAP_THRESHOLD, 16'hF000);          // upper bits dropped
          set_reg(REG_SATURATION_LEVEL, 16'h0FFF);
          set_reg(REG_TOP_SPEED, 16'hFFFF);
          set_reg(REG_HEADING_BAND, 16'd0);
          set_reg(REG_ARRIVE_RADIUS, 16'hFFFF);
          set_reg(REG_TARGET_X, 16'h8000);
          set_reg(REG_TARGET_Z, 16'h7FFF);
        end
        2: begin
          set_reg(REG_GAP_THRESHOLD, 16'hFFFF);
          set_reg(REG_SATURATION_LEVEL, 16'd1);          // below gap
          set_reg(REG_TOP_SPEED, 16'd0);
          set_reg(REG_HEADING_BAND, 16'd12868);
          set_reg(REG_ARRIVE_RADIUS, 16'd0);
          set_reg(REG_TARGET_X, 16'h7FFF);
          set_reg(REG_TARGET_Z, 16'h8000);
          calm = 1;
        end
        3: begin
          set_reg(REG_GAP_THRESHOLD, 16'd300);
          set_reg(REG_SATURATION_LEVEL, 16'd301);
          set_reg(REG_TOP_SPEED, 16'd200);
          set_reg(REG_HEADING_BAND, 16'hFFFF);
          set_reg(REG_ARRIVE_RADIUS, 16'd300);
          set_reg(REG_TARGET_X, 16'd1234);
          set_reg(REG_TARGET_Z, -16'sd4000);
          calm = 0;
          hold_req = 1;
        end
        4: begin
          set_reg(REG_GAP_THRESHOLD, 16'd1000);
          set_reg(REG_SATURATION_LEVEL, 16'd3000);
          set_reg(REG_TOP_SPEED, 16'd97);
          set_reg(REG_HEADING_BAND, 16'd50);
          set_reg(REG_ARRIVE_RADIUS, 16'd1000);
          set_reg(REG_TARGET_X, -16'sd256);
          set_reg(REG_TARGET_Z, 16'd256);
        end
        5: begin
          set_reg(REG_GAP_THRESHOLD, 16'd600);
          set_reg(REG_SATURATION_LEVEL, 16'd1024);
          set_reg(REG_TOP_SPEED, 16'd12);
          set_reg(REG_HEADING_BAND, 16'd410);
          set_reg(REG_ARRIVE_RADIUS, 16'd26);
          set_reg(REG_TARGET_X, 16'd0);
          set_reg(REG_TARGET_Z, 16'd896);
        end
        default: ;
      endcase
      cfg_write <= 1'b0;
      @(posedge clk);
      repeat (160) send_item(rand_item());
      drain();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
